FILE: design/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants for the bounded double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned CMD_W      = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_NOP        = 3'd4
  } dq_cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [VALUE_W-1:0] value;
  } dq_cmd_t;

  typedef struct packed {
    logic [VALUE_W-1:0] front_value;
    logic [VALUE_W-1:0] back_value;
    logic [COUNT_W-1:0] entry_count;
    logic               is_empty;
    logic               is_full;
    logic               op_error;
  } dq_res_t;

  typedef struct packed {
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  re;
    logic [IDX_W-1:0]      raddr_front;
    logic [IDX_W-1:0]      raddr_back;
  } dq_ram_req_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] front;
    logic [DATA_WIDTH-1:0] back;
  } dq_ram_rsp_t;

endpackage

FILE: design/double_ended_queue_core.sv
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded double-ended queue on a ring of slots with a head pointer and count.
// ----------------------------------------------------------------------------
// Each command is sequenced through the ST_READ and ST_RESP states: the store
// is written at accept, read once in ST_READ, and the result is shown with
// done_o in ST_RESP. A new command can be accepted while the previous result
// is shown; busy is high only during the store read cycle.
// Reset clears the head pointer and count; the slot store is not cleared.
// The receiver cannot stall: each result is valid for exactly one cycle.
module double_ended_queue_core
  import dq_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  dq_cmd_t cmd_i,
  output logic    done_o,
  output dq_res_t res_o
);

  dq_ram_req_t ram_req;
  dq_ram_rsp_t ram_rsp;

  dq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .cmd_i     (cmd_i),
    .ram_req_o (ram_req),
    .ram_rsp_i (ram_rsp),
    .done_o    (done_o),
    .res_o     (res_o)
  );

  dq_ram u_ram (
    .clk_i (clk_i),
    .req_i (ram_req),
    .rsp_o (ram_rsp)
  );

endmodule

FILE: design/dq_ram.sv
// ----------------------------------------------------------------------------
// dq_ram
// Slot store: one write port and two registered read ports.
// ----------------------------------------------------------------------------
module dq_ram
  import dq_pkg::*;
(
  input  logic        clk_i,
  input  dq_ram_req_t req_i,
  output dq_ram_rsp_t rsp_o
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_front_q;
  logic [DATA_WIDTH-1:0] rd_back_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_front_q <= mem[req_i.raddr_front];
      rd_back_q  <= mem[req_i.raddr_back];
    end
  end

  assign rsp_o.front = rd_front_q;
  assign rsp_o.back  = rd_back_q;

endmodule

FILE: design/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl
// Head pointer, entry count and sequencing of the slot store accesses.
// ----------------------------------------------------------------------------
module dq_ctrl
  import dq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  dq_cmd_t     cmd_i,
  output dq_ram_req_t ram_req_o,
  input  dq_ram_rsp_t ram_rsp_i,
  output logic        done_o,
  output dq_res_t     res_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_RESP
  } state_e;

  localparam logic [CNT_W-1:0] DepthCnt = CNT_W'(DEPTH);
  localparam logic [IDX_W-1:0] LastIdx  = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W:0]   DepthSum = (CNT_W + 1)'(DEPTH);

  state_e           state_q;
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             err_q, err_d;

  logic             accept;
  logic             q_full, q_empty;
  logic [IDX_W-1:0] head_inc, head_dec, tail_pos, back_pos;
  logic [CNT_W:0]   tail_sum, back_sum;

  assign accept  = start && !busy;
  assign busy    = (state_q == ST_READ);
  assign q_full  = (count_q == DepthCnt);
  assign q_empty = (count_q == '0);

  assign head_inc = (head_q == LastIdx) ? '0 : head_q + 1'b1;
  assign head_dec = (head_q == '0) ? LastIdx : head_q - 1'b1;

  // Sums stay below twice the depth, so one conditional subtract wraps them.
  assign tail_sum = (CNT_W + 1)'(head_q) + (CNT_W + 1)'(count_q);
  assign tail_pos = (tail_sum >= DepthSum) ? IDX_W'(tail_sum - DepthSum) : IDX_W'(tail_sum);
  assign back_sum = tail_sum - 1'b1;
  assign back_pos = q_empty ? head_q :
                    (back_sum >= DepthSum) ? IDX_W'(back_sum - DepthSum) : IDX_W'(back_sum);

  always_comb begin
    head_d          = head_q;
    count_d         = count_q;
    err_d           = 1'b0;
    ram_req_o.we    = 1'b0;
    ram_req_o.waddr = tail_pos;
    ram_req_o.wdata = cmd_i.value[DATA_WIDTH-1:0];
    // The write lands at the accept edge, so the read issued in the next cycle
    // already sees it.
    ram_req_o.re          = (state_q == ST_READ);
    ram_req_o.raddr_front = head_q;
    ram_req_o.raddr_back  = back_pos;
    unique case (cmd_i.command)
      CMD_PUSH_BACK: begin
        if (q_full) begin
          err_d = 1'b1;
        end else begin
          ram_req_o.we = accept;
          count_d      = count_q + 1'b1;
        end
      end
      CMD_PUSH_FRONT: begin
        if (q_full) begin
          err_d = 1'b1;
        end else begin
          ram_req_o.we    = accept;
          ram_req_o.waddr = head_dec;
          head_d          = head_dec;
          count_d         = count_q + 1'b1;
        end
      end
      CMD_POP_BACK: begin
        if (q_empty) begin
          err_d = 1'b1;
        end else begin
          count_d = count_q - 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (q_empty) begin
          err_d = 1'b1;
        end else begin
          head_d  = head_inc;
          count_d = count_q - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      count_q <= '0;
      err_q   <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE, ST_RESP: begin
          if (accept) begin
            state_q <= ST_READ;
            head_q  <= head_d;
            count_q <= count_d;
            err_q   <= err_d;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_READ: begin
          state_q <= ST_RESP;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign done_o            = (state_q == ST_RESP);
  assign res_o.front_value = q_empty ? '0 : VALUE_W'(ram_rsp_i.front);
  assign res_o.back_value  = q_empty ? '0 : VALUE_W'(ram_rsp_i.back);
  assign res_o.entry_count = COUNT_W'(count_q);
  assign res_o.is_empty    = q_empty;
  assign res_o.is_full     = q_full;
  assign res_o.op_error    = err_q;

endmodule

FILE: verif/double_ended_queue_core_tb.sv
// ----------------------------------------------------------------------------
// double_ended_queue_core_tb
// Self-checking bench for the bounded double-ended queue. A short table of
// commands exercises empty and full queues, unused codes and pointer wrap,
// then biased random traffic drives the occupancy between both bounds.
// Results are checked against a row's own view, if any, else a shadow deque.
// ----------------------------------------------------------------------------
module double_ended_queue_core_tb;
  import dq_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

  localparam int unsigned RANDOM_OPS = 1550;
  localparam int unsigned PLAN_ROWS  = 20;

  localparam dq_res_t EMPTY_VIEW = '{32'h0, 32'h0, 5'd0, 1'b1, 1'b0, 1'b0};
  localparam dq_res_t EMPTY_ERR  = '{32'h0, 32'h0, 5'd0, 1'b1, 1'b0, 1'b1};

  typedef struct {
    logic [CMD_W-1:0]   command;
    logic [VALUE_W-1:0] value;
    int unsigned        reps;
    bit                 typed;
    dq_res_t            view;
  } plan_row_t;

  logic    clk_i = 1'b0;
  logic    rst_ni;
  logic    start;
  logic    busy;
  dq_cmd_t cmd_i;
  logic    done_o;
  dq_res_t res_o;

  // Shadow copy of the deque.
  logic [VALUE_W-1:0] shadow_slot [DEPTH];
  int unsigned        shadow_head;
  int unsigned        shadow_count;

  dq_res_t     expected_views[$];
  int unsigned mismatch_count;

  double_ended_queue_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_i  (cmd_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Applies one command to the shadow deque and returns the view it leaves.
  function automatic dq_res_t deque_apply(dq_cmd_t c);
    dq_res_t r;
    r = '0;
    case (c.command)
      CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
        if (shadow_count >= DEPTH) begin
          r.op_error = 1'b1;
        end else if (c.command == CMD_PUSH_BACK) begin
          shadow_slot[(shadow_head + shadow_count) % DEPTH] = c.value;
          shadow_count++;
        end else begin
          shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
          shadow_slot[shadow_head] = c.value;
          shadow_count++;
        end
      end
      CMD_POP_BACK, CMD_POP_FRONT: begin
        if (shadow_count == 0) begin
          r.op_error = 1'b1;
        end else begin
          if (c.command == CMD_POP_FRONT) shadow_head = (shadow_head + 1) % DEPTH;
          shadow_count--;
        end
      end
      default: ;
    endcase
    if (shadow_count != 0) begin
      r.front_value = shadow_slot[shadow_head];
      r.back_value  = shadow_slot[(shadow_head + shadow_count - 1) % DEPTH];
    end
    r.entry_count = COUNT_W'(shadow_count);
    r.is_empty    = (shadow_count == 0);
    r.is_full     = (shadow_count >= DEPTH);
    return r;
  endfunction

  // Mostly back-to-back, sometimes a short gap, rarely a long pause.
  function automatic int unsigned next_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic drive_command(input dq_cmd_t c, input int unsigned gap,
                               input bit has_view, input dq_res_t view);
    dq_res_t predicted;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy !== 1'b0);
    predicted = deque_apply(c);
    expected_views.push_back(has_view ? view : predicted);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (expected_views.size() == 0) begin
        if (mismatch_count < 10) $display("Unexpected result transaction: %p", res_o);
        mismatch_count++;
      end else begin
        dq_res_t want;
        want = expected_views.pop_front();
        if (res_o.front_value !== want.front_value || res_o.back_value !== want.back_value ||
            res_o.entry_count !== want.entry_count || res_o.is_empty !== want.is_empty ||
            res_o.is_full !== want.is_full || res_o.op_error !== want.op_error) begin
          if (mismatch_count < 10) begin
            $display("Mismatch: front %h/%h back %h/%h count %0d/%0d",
                     want.front_value, res_o.front_value, want.back_value,
                     res_o.back_value, want.entry_count, res_o.entry_count);
            $display("          empty %b/%b full %b/%b error %b/%b (expected/actual)",
                     want.is_empty, res_o.is_empty, want.is_full, res_o.is_full,
                     want.op_error, res_o.op_error);
          end
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    plan_row_t   plan [PLAN_ROWS];
    dq_cmd_t     c;
    int unsigned ops_sent;
    int unsigned seg_left;
    int unsigned push_pct;
    bit          quiet;

    rst_ni <= 1'b0;
    start <= 1'b0;
    cmd_i <= '0;
    mismatch_count = 0;
    shadow_head = 0;
    shadow_count = 0;

    plan[0]  = '{CMD_POP_FRONT,  32'h0,         1,  1'b1, EMPTY_ERR};
    plan[1]  = '{CMD_POP_BACK,   32'h0,         1,  1'b1, EMPTY_ERR};
    plan[2]  = '{CMD_NOP,        32'hFFFF_FFFF, 1,  1'b1, EMPTY_VIEW};
    plan[3]  = '{CMD_RSVD5,      32'h1234_5678, 1,  1'b1, EMPTY_VIEW};
    plan[4]  = '{CMD_RSVD6,      32'h0,         1,  1'b1, EMPTY_VIEW};
    plan[5]  = '{CMD_RSVD7,      32'hFFFF_FFFF, 1,  1'b1, EMPTY_VIEW};
    plan[6]  = '{CMD_PUSH_BACK,  32'hFFFF_FFFF, 1,  1'b1,
                 '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd1, 1'b0, 1'b0, 1'b0}};
    plan[7]  = '{CMD_PUSH_FRONT, 32'h0,         1,  1'b1,
                 '{32'h0, 32'hFFFF_FFFF, 5'd2, 1'b0, 1'b0, 1'b0}};
    plan[8]  = '{CMD_POP_BACK,   32'h0,         1,  1'b1,
                 '{32'h0, 32'h0, 5'd1, 1'b0, 1'b0, 1'b0}};
    plan[9]  = '{CMD_POP_FRONT,  32'h0,         1,  1'b1, EMPTY_VIEW};
    // Fill from the front so the head wraps backward, then push against full.
    plan[10] = '{CMD_PUSH_FRONT, 32'h8000_0000, 16, 1'b0, '0};
    plan[11] = '{CMD_PUSH_BACK,  32'hDEAD_BEEF, 1,  1'b0, '0};
    plan[12] = '{CMD_PUSH_FRONT, 32'hCAFE_F00D, 1,  1'b0, '0};
    plan[13] = '{CMD_NOP,        32'h0,         1,  1'b0, '0};
    plan[14] = '{CMD_POP_BACK,   32'h0,         17, 1'b0, '0};
    plan[15] = '{CMD_PUSH_BACK,  32'h5555_5555, 16, 1'b0, '0};
    plan[16] = '{CMD_POP_FRONT,  32'h0,         8,  1'b0, '0};
    // The tail now wraps past the end of the ring.
    plan[17] = '{CMD_PUSH_BACK,  32'hAAAA_AAAA, 8,  1'b0, '0};
    plan[18] = '{CMD_PUSH_FRONT, 32'h0F0F_0F0F, 1,  1'b0, '0};
    plan[19] = '{CMD_POP_FRONT,  32'h0,         17, 1'b0, '0};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      for (int unsigned k = 0; k < plan[i].reps; k++) begin
        c.command = plan[i].command;
        c.value   = plan[i].value + k * 32'h0101_0101;
        drive_command(c, next_gap(), plan[i].typed, plan[i].view);
      end
    end

    // Segments with a push bias walk the occupancy between empty and full.
    ops_sent = 0;
    seg_left = 0;
    push_pct = 50;
    quiet = 1'b0;
    while (ops_sent < RANDOM_OPS) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 120);
        case ($urandom_range(0, 2))
          0:       push_pct = 15;
          1:       push_pct = 50;
          default: push_pct = 85;
        endcase
        quiet = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 99) < 8) c.command = CMD_W'($urandom_range(CMD_NOP, CMD_RSVD7));
      else if ($urandom_range(0, 99) < push_pct)
        c.command = CMD_W'($urandom_range(CMD_PUSH_BACK, CMD_PUSH_FRONT));
      else c.command = CMD_W'($urandom_range(CMD_POP_BACK, CMD_POP_FRONT));
      case ($urandom_range(0, 9))
        0:       c.value = '0;
        1:       c.value = '1;
        default: c.value = $urandom;
      endcase
      drive_command(c, quiet ? 0 : next_gap(), 1'b0, '0);
      ops_sent++;
      seg_left--;
    end
    start <= 1'b0;

    for (int w = 0; w < 100 && expected_views.size() != 0; w++) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (expected_views.size() != 0) begin
      $display("%0d result transactions never arrived", expected_views.size());
      mismatch_count += expected_views.size();
    end

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
